>>> hdl/sha256_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package sha256_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_UPDATE,
    ST_EMIT
  } ctrl_state_e;

  // Source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift_en;
    byte_sel_e  byte_sel;
    logic       count_bits;
    logic       load_v;
    logic       round_en;
    logic [5:0] round;
    logic       update;
    logic       restart;
    logic [2:0] word_sel;
  } dp_cmd_t;

  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

>>> hdl/sha256_if.sv
// Valid/ready channel interfaces for message bytes in and digest words out.
// Standalone; no package dependency.
`default_nettype none

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

>>> hdl/sha256_dp.sv
// SHA-256 datapath: block window / message schedule, working variables,
// chaining words and bit count. Depends on sha256_pkg.
`default_nettype none

module sha256_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sha256_pkg::dp_cmd_t cmd_i,
  input  wire logic [7:0]          data_byte_i,
  output logic [31:0]              digest_word_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned amt);
    rotr = (x >> amt) | (x << (32 - amt));
  endfunction

  logic [31:0]  chain_q [8];
  logic [31:0]  chain_d [8];
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [511:0] w_q;
  logic [511:0] w_d;
  logic [63:0]  bits_q;
  logic [63:0]  bits_d;
  logic [7:0]   shift_byte;
  logic [31:0]  w_next;
  logic [31:0]  w_lo;
  logic [31:0]  w_hi;
  logic [31:0]  big0;
  logic [31:0]  big1;
  logic [31:0]  choose;
  logic [31:0]  major;
  logic [31:0]  t_one;
  logic [31:0]  t_two;

  // Pick the byte that enters the window
  always_comb begin
    case (cmd_i.byte_sel)
      sha256_pkg::SEL_MSG:   shift_byte = data_byte_i;
      sha256_pkg::SEL_PAD80: shift_byte = sha256_pkg::PAD_BYTE;
      sha256_pkg::SEL_ZERO:  shift_byte = 8'h00;
      sha256_pkg::SEL_LEN:   shift_byte = bits_q[63:56];
      default:               shift_byte = 8'h00;
    endcase
  end

  // Schedule word sixteen ahead of the word at the top of the window
  always_comb begin
    w_lo   = w_q[32*14 +: 32];
    w_hi   = w_q[32*1 +: 32];
    w_next = w_q[32*15 +: 32]
           + (rotr(w_lo, 7) ^ rotr(w_lo, 18) ^ (w_lo >> 3))
           + w_q[32*6 +: 32]
           + (rotr(w_hi, 17) ^ rotr(w_hi, 19) ^ (w_hi >> 10));
  end

  // One compression round
  always_comb begin
    big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t_one  = v_q[7] + big1 + choose + sha256_pkg::ROUND_K[cmd_i.round]
           + w_q[32*15 +: 32];
    big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t_two  = big0 + major;
  end

  // Next values of window and working variables
  always_comb begin
    w_d = w_q;
    v_d = v_q;
    if (cmd_i.shift_en) begin
      w_d = {w_q[503:0], shift_byte};
    end else if (cmd_i.round_en) begin
      w_d = {w_q[479:0], w_next};
    end
    if (cmd_i.load_v) begin
      v_d = chain_q;
    end else if (cmd_i.round_en) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t_one;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t_one + t_two;
    end
  end

  // Next values of chaining words and bit count
  always_comb begin
    chain_d = chain_q;
    bits_d  = bits_q;
    if (cmd_i.restart) begin
      chain_d = sha256_pkg::INIT_HASH;
      bits_d  = 64'd0;
    end else begin
      if (cmd_i.update) begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
      end
      if (cmd_i.count_bits) begin
        bits_d = bits_q + 64'd8;
      end else if (cmd_i.shift_en && cmd_i.byte_sel == sha256_pkg::SEL_LEN) begin
        bits_d = {bits_q[55:0], 8'h00};
      end
    end
  end

  // Chaining words and bit count; reset loads the initial hash and clears the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha256_pkg::INIT_HASH;
      bits_q  <= 64'd0;
    end else begin
      chain_q <= chain_d;
      bits_q  <= bits_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  assign digest_word_o = chain_q[cmd_i.word_sel];

endmodule

`default_nettype wire

>>> hdl/sha256_ctrl.sv
// SHA-256 controller: byte fill count, padding sequence, round count and
// digest output sequencing. Depends on sha256_pkg.
`default_nettype none

module sha256_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output sha256_pkg::dp_cmd_t cmd_o
);

  sha256_pkg::ctrl_state_e state_q;
  sha256_pkg::ctrl_state_e state_d;
  sha256_pkg::byte_sel_e   pad_sel;
  logic [5:0] fill_q;
  logic [5:0] round_q;
  logic [2:0] idx_q;
  logic       finish_q;
  logic       sent80_q;
  logic       len_ok_q;
  logic       in_acc;
  logic       out_acc;
  logic       msg_shift;
  logic       shift;
  logic       block_done;
  logic       emit_done;

  assign in_acc     = in_valid_i && (state_q == sha256_pkg::ST_IDLE);
  assign out_acc    = out_ready_i && (state_q == sha256_pkg::ST_EMIT);
  assign msg_shift  = in_acc && byte_present_i;
  assign shift      = msg_shift || (state_q == sha256_pkg::ST_PAD);
  assign block_done = shift && (fill_q == sha256_pkg::LAST_FILL);
  assign emit_done  = out_acc && (idx_q == sha256_pkg::LAST_WORD);

  // Padding byte: marker, then zeros, then length in the final block
  always_comb begin
    if (!sent80_q) begin
      pad_sel = sha256_pkg::SEL_PAD80;
    end else if (len_ok_q && fill_q >= sha256_pkg::LEN_START) begin
      pad_sel = sha256_pkg::SEL_LEN;
    end else begin
      pad_sel = sha256_pkg::SEL_ZERO;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (block_done) begin
            state_d = sha256_pkg::ST_COMP;
          end else if (end_of_message_i) begin
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (block_done) begin
          state_d = sha256_pkg::ST_COMP;
        end
      end
      sha256_pkg::ST_COMP: begin
        if (round_q == sha256_pkg::LAST_ROUND) begin
          state_d = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        if (!finish_q) begin
          state_d = sha256_pkg::ST_IDLE;
        end else if (len_ok_q) begin
          state_d = sha256_pkg::ST_EMIT;
        end else begin
          state_d = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o  = (state_q == sha256_pkg::ST_IDLE);
    out_valid_o = (state_q == sha256_pkg::ST_EMIT);
    word_index_o = idx_q;
    last_word_o  = (idx_q == sha256_pkg::LAST_WORD);
    cmd_o.shift_en   = shift;
    cmd_o.byte_sel   = (state_q == sha256_pkg::ST_PAD) ? pad_sel : sha256_pkg::SEL_MSG;
    cmd_o.count_bits = msg_shift;
    cmd_o.load_v     = block_done;
    cmd_o.round_en   = (state_q == sha256_pkg::ST_COMP);
    cmd_o.round      = round_q;
    cmd_o.update     = (state_q == sha256_pkg::ST_UPDATE);
    cmd_o.restart    = emit_done;
    cmd_o.word_sel   = idx_q;
  end

  // Advance state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::ST_IDLE;
      fill_q   <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      finish_q <= 1'b0;
      sent80_q <= 1'b0;
      len_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        fill_q <= fill_q + 6'd1;
      end
      if (state_q == sha256_pkg::ST_COMP) begin
        round_q <= round_q + 6'd1;
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
      if (in_acc && end_of_message_i) begin
        finish_q <= 1'b1;
      end
      if (state_q == sha256_pkg::ST_PAD && !sent80_q) begin
        sent80_q <= 1'b1;
        if (fill_q < sha256_pkg::LEN_START) begin
          len_ok_q <= 1'b1;
        end
      end
      if (state_q == sha256_pkg::ST_UPDATE && finish_q && sent80_q) begin
        len_ok_q <= 1'b1;
      end
      if (emit_done) begin
        finish_q <= 1'b0;
        sent80_q <= 1'b0;
        len_ok_q <= 1'b0;
      end
    end
  end

  // Digest goes out only after a full block boundary
  a_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::ST_EMIT) |-> (fill_q == 6'd0 && round_q == 6'd0))
    else $error("digest emitted with pending bytes or rounds");

  // Length bytes only after the padding marker
  a_len_after_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_ok_q |-> sent80_q)
    else $error("length phase without padding marker");

  // Message is closed down after the last digest word
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_done |=> (state_q == sha256_pkg::ST_IDLE && !finish_q && idx_q == 3'd0))
    else $error("hasher not restarted after digest");

  // Compression always begins at round zero
  a_round_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_done |=> (state_q == sha256_pkg::ST_COMP && round_q == 6'd0))
    else $error("compression started mid-sequence");

endmodule

`default_nettype wire

>>> hdl/sha256_stream_hasher.sv
// SHA-256 over a byte stream: top level joining controller and datapath.
// Depends on sha256_pkg, sha256_in_if, sha256_out_if, sha256_ctrl, sha256_dp.
//
//   port    dir  beat                                      accept
//   msg_i   in   data_byte[8], byte_present, end_of_message valid && ready
//   dig_o   out  digest_word[32], word_index[3], last_word  valid && ready
//
// Message bytes are taken one per cycle while a block fills.
// Each full block closes the input while the shared round unit runs the
// compression rounds and the result is added into the chaining words.
// End of message shifts in padding one byte per cycle, over one or two
// compressions, then offers eight digest beats.
// Output stalls hold the digest beat; no input is taken until the last beat.
// Reset loads the initial hash values and clears the bit count at once.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sha256_in_if.sink   msg_i,
  sha256_out_if.source dig_o
);

  sha256_pkg::dp_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (msg_i.valid),
    .byte_present_i   (msg_i.byte_present),
    .end_of_message_i (msg_i.end_of_message),
    .in_ready_o       (msg_i.ready),
    .out_valid_o      (dig_o.valid),
    .out_ready_i      (dig_o.ready),
    .word_index_o     (dig_o.word_index),
    .last_word_o      (dig_o.last_word),
    .cmd_o            (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (msg_i.data_byte),
    .digest_word_o (dig_o.digest_word)
  );

endmodule

`default_nettype wire
